// File: rtl/tdbc_pkg.sv
`default_nettype none
package tdbc_pkg;

   localparam int PAD_COUNT = 6;
   localparam logic [6:0] DUTY_FULL = 7'd100;

   // pad positions in the touch mask
   localparam int PAD_OFF = 0;
   localparam int PAD_ON = 1;
   localparam int PAD_BRIGHTER = 2;
   localparam int PAD_DIMMER = 3;
   localparam int PAD_FASTER = 4;
   localparam int PAD_SLOWER = 5;

   // register indexes on the csr port
   localparam logic [2:0] REG_TICK_MS = 3'd0;
   localparam logic [2:0] REG_DUTY_STEP = 3'd1;
   localparam logic [2:0] REG_HP_INITIAL = 3'd2;
   localparam logic [2:0] REG_HP_STEP = 3'd3;
   localparam logic [2:0] REG_HP_MIN = 3'd4;
   localparam logic [2:0] REG_HP_MAX = 3'd5;

   typedef struct packed {
      logic [9:0]  tick_ms;
      logic [6:0]  duty_step;
      logic [13:0] hp_initial;
      logic [13:0] hp_step;
      logic [13:0] hp_min;
      logic [13:0] hp_max;
   } cfg_type;

   typedef struct packed {
      logic [PAD_COUNT-1:0] prev_touch;
      logic [6:0]           duty_level;
      logic                 blink_active;
      logic [13:0]          half_period;
      logic [14:0]          blink_timer;
      logic                 lamp_phase;
   } state_type;

   // limit to max first, then raise to min, so min wins when they cross
   function automatic logic [13:0] clamp_period(input logic [14:0] v,
                                                input logic [13:0] lo,
                                                input logic [13:0] hi);
      logic [14:0] r;
      r = v;
      if (r > {1'b0, hi}) r = {1'b0, hi};
      if (r < {1'b0, lo}) r = {1'b0, lo};
      return r[13:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/touch_dimmer_blink_controller_core.sv
`default_nettype none
// Touch dimmer with blink mode. Each request is one tick carrying the six pad
// states (bit 0 off, 1 full on, 2 brighter, 3 dimmer, 4 faster, 5 slower);
// a pad acts on its rising edge and the lowest pressed pad wins. Every request
// gives exactly one response the cycle after it is accepted, and a request can
// be accepted every cycle: the tick's whole state update runs through one pass
// of next-state logic into the state and response registers. req_tready drops
// only while a response is held and rsp_tready is low. Write the csr registers
// (0 tick_ms, 1 duty_step, 2 half_period_initial, 3 half_period_step,
// 4 half_period_min, 5 half_period_max) only while no request is in flight.
module touch_dimmer_blink_controller_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [5:0] touch_mask, [7:6] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [6:0] drive_duty, [13:7] duty_setting, [14] blink_on,
   // [28:15] half_period_now, [31:29] zero
   output logic [31:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [13:0] csr_data
);

   tdbc_pkg::cfg_type   cfg_ff;
   tdbc_pkg::state_type state_ff;
   tdbc_pkg::state_type state_in;
   logic [6:0]          drive_in;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_data_ff;
   logic                take;

   assign csr_ready = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms <= 10'd100;
         cfg_ff.duty_step <= 7'd10;
         cfg_ff.hp_initial <= 14'd500;
         cfg_ff.hp_step <= 14'd100;
         cfg_ff.hp_min <= 14'd100;
         cfg_ff.hp_max <= 14'd2000;
      end else if (csr_valid) begin
         case (csr_index)
            tdbc_pkg::REG_TICK_MS:    cfg_ff.tick_ms <= csr_data[9:0];
            tdbc_pkg::REG_DUTY_STEP:  cfg_ff.duty_step <= csr_data[6:0];
            tdbc_pkg::REG_HP_INITIAL: cfg_ff.hp_initial <= csr_data;
            tdbc_pkg::REG_HP_STEP:    cfg_ff.hp_step <= csr_data;
            tdbc_pkg::REG_HP_MIN:     cfg_ff.hp_min <= csr_data;
            tdbc_pkg::REG_HP_MAX:     cfg_ff.hp_max <= csr_data;
            default: ;
         endcase
      end
   end

   tdbc_next u_next (
      .cfg   (cfg_ff),
      .cur   (state_ff),
      .touch (req_tdata[tdbc_pkg::PAD_COUNT-1:0]),
      .nxt   (state_in),
      .drive (drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.prev_touch <= '0;
         state_ff.duty_level <= 7'd0;
         state_ff.blink_active <= 1'b0;
         state_ff.half_period <= 14'd500;
         state_ff.blink_timer <= 15'd0;
         state_ff.lamp_phase <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= {3'd0, state_in.half_period, state_in.blink_active,
                         state_in.duty_level, drive_in};
      end
   end

endmodule
`default_nettype wire

// File: rtl/tdbc_next.sv
`default_nettype none
module tdbc_next (
   input  wire tdbc_pkg::cfg_type              cfg,
   input  wire tdbc_pkg::state_type            cur,
   input  wire [tdbc_pkg::PAD_COUNT-1:0]       touch,
   output tdbc_pkg::state_type                 nxt,
   output logic [6:0]                          drive
);

   logic [tdbc_pkg::PAD_COUNT-1:0] press;
   logic [7:0]  duty_sum;
   logic [6:0]  duty_up;
   logic [6:0]  duty_dn;
   logic [14:0] hp_fast_raw;
   logic [14:0] hp_slow_raw;
   logic        start;
   logic [14:0] timer_base;
   logic        phase_base;
   logic [14:0] timer_sum;

   assign press = touch & ~cur.prev_touch;

   assign duty_sum = {1'b0, cur.duty_level} + {1'b0, cfg.duty_step};
   assign duty_up = (cur.duty_level >= tdbc_pkg::DUTY_FULL) ? cur.duty_level :
                    (duty_sum > {1'b0, tdbc_pkg::DUTY_FULL}) ? tdbc_pkg::DUTY_FULL :
                    duty_sum[6:0];
   assign duty_dn = (cur.duty_level >= cfg.duty_step) ?
                    7'(cur.duty_level - cfg.duty_step) : 7'd0;

   assign hp_fast_raw = (cur.half_period > cfg.hp_step) ?
                        {1'b0, 14'(cur.half_period - cfg.hp_step)} : 15'd0;
   assign hp_slow_raw = {1'b0, cur.half_period} + {1'b0, cfg.hp_step};

   assign start = !cur.blink_active && (press[tdbc_pkg::PAD_OFF] == 1'b0) &&
                  (press[tdbc_pkg::PAD_ON] == 1'b0) &&
                  (press[tdbc_pkg::PAD_BRIGHTER] == 1'b0) &&
                  (press[tdbc_pkg::PAD_DIMMER] == 1'b0) &&
                  (press[tdbc_pkg::PAD_FASTER] || press[tdbc_pkg::PAD_SLOWER]);

   // a fresh blink starts with a cleared timer and a lit lamp
   assign timer_base = start ? 15'd0 : cur.blink_timer;
   assign phase_base = start ? 1'b1 : cur.lamp_phase;
   assign timer_sum = 15'({1'b0, timer_base} + {6'd0, cfg.tick_ms});

   always_comb begin
      nxt = cur;
      nxt.prev_touch = touch;
      if (press[tdbc_pkg::PAD_OFF]) begin
         nxt.duty_level = 7'd0;
         nxt.blink_active = 1'b0;
      end else if (press[tdbc_pkg::PAD_ON]) begin
         nxt.duty_level = tdbc_pkg::DUTY_FULL;
         nxt.blink_active = 1'b0;
      end else if (press[tdbc_pkg::PAD_BRIGHTER]) begin
         nxt.duty_level = duty_up;
      end else if (press[tdbc_pkg::PAD_DIMMER]) begin
         nxt.duty_level = duty_dn;
      end else if (start) begin
         nxt.blink_active = 1'b1;
         nxt.half_period = tdbc_pkg::clamp_period({1'b0, cfg.hp_initial},
                                                  cfg.hp_min, cfg.hp_max);
      end else if (press[tdbc_pkg::PAD_FASTER]) begin
         nxt.half_period = tdbc_pkg::clamp_period(hp_fast_raw, cfg.hp_min, cfg.hp_max);
      end else if (press[tdbc_pkg::PAD_SLOWER]) begin
         nxt.half_period = tdbc_pkg::clamp_period(hp_slow_raw, cfg.hp_min, cfg.hp_max);
      end

      drive = nxt.duty_level;
      if (nxt.blink_active) begin
         if (timer_sum >= {1'b0, nxt.half_period}) begin
            nxt.blink_timer = 15'd0;
            nxt.lamp_phase = !phase_base;
         end else begin
            nxt.blink_timer = timer_sum;
            nxt.lamp_phase = phase_base;
         end
         drive = nxt.lamp_phase ? nxt.duty_level : 7'd0;
      end
   end

endmodule
`default_nettype wire
